[rtl/core/wwls_pkg.sv]
// Shared types, constants and register indexes of the windowed weighted level scheduler.
package wwls_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int WEIGHT_W       = 5;
  localparam int LEVEL_W        = 2;
  localparam int CFG_INDEX_W    = 2;
  localparam int NUM_LEVELS     = 3;

  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [WEIGHT_W-1:0]    weight_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam level_t LEVEL_HIGH = 2'd0;
  localparam level_t LEVEL_MED  = 2'd1;
  localparam level_t LEVEL_LOW  = 2'd2;

  localparam cfg_index_t REG_WEIGHT_HIGH = 2'd0;
  localparam cfg_index_t REG_WEIGHT_MED  = 2'd1;
  localparam cfg_index_t REG_WEIGHT_LOW  = 2'd2;

  localparam weight_t WEIGHT_HIGH_RST = 5'd9;
  localparam weight_t WEIGHT_MED_RST  = 5'd6;
  localparam weight_t WEIGHT_LOW_RST  = 5'd4;

  // Outcome of one selection
  typedef struct packed {
    level_t level;
    logic   none;
  } pick_t;

endpackage

[rtl/core/windowed_weighted_level_scheduler_top.sv]
// Top level of the windowed weighted level scheduler.
//
// Each request on the in channel (in_valid/in_ready) carries three ready flags,
// one per priority level; each request gives exactly one result on the out
// channel (out_valid/out_ready): selected_level and none_ready.
// The weights are written through the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data), index 0 high, 1 med, 2 low; index 3 is ignored.
// The result sits in the output register the cycle after the request is taken.
// Throughput is one request per cycle while in_ready is high, set by one ring
// write, one registered ring read of the oldest pick and the count update.
// The output register holds while the receiver stalls; in_ready stays high as
// long as the held result is taken in the same cycle.
// After weights are lowered, the first request is handled as usual and the
// block then drops (occupancy - window length) further old picks, one per cycle,
// with in_ready and cfg_ready low; otherwise no such cycles occur.
// Reset sets the weights to 9, 6 and 4, empties the window and marks the
// history unstarted. The ring contents need no clearing.
module windowed_weighted_level_scheduler_top
  import wwls_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       ready_high,
  input  logic       ready_med,
  input  logic       ready_low,
  output logic       out_valid,
  input  logic       out_ready,
  output level_t     selected_level,
  output logic       none_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  weight_t    cfg_data
);

  localparam int CW = $clog2(WINDOW_MAX+1);
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int SW = ((CW + 2) > (WEIGHT_W + 2)) ? (CW + 2) : (WEIGHT_W + 2);

  weight_t           weights [NUM_LEVELS];
  logic [CW-1:0]     counts  [NUM_LEVELS];
  logic [CW-1:0]     counts_next [NUM_LEVELS];
  logic [AW-1:0]     window_start;
  logic [AW-1:0]     window_start_next;
  logic              history_started;
  logic              trim;
  logic              trim_next;

  logic              in_acc;
  logic              append;
  logic              evict;
  logic [SW-1:0]     weight_sum;
  logic [SW-1:0]     window_len;
  logic [SW-1:0]     occ;
  logic [SW-1:0]     occ_next;
  logic [SW:0]       wr_sum;
  logic [AW-1:0]     wr_addr;
  level_t            oldest;
  pick_t             pick;

  // Accept requests unless dropping old picks or holding an untaken result
  assign in_ready  = !trim && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = !trim;

  // Weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weights[0] <= WEIGHT_HIGH_RST;
      weights[1] <= WEIGHT_MED_RST;
      weights[2] <= WEIGHT_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEIGHT_HIGH: weights[0] <= cfg_data;
        REG_WEIGHT_MED:  weights[1] <= cfg_data;
        REG_WEIGHT_LOW:  weights[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the level
  wwls_pick #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_pick (
    .rdy     ({ready_low, ready_med, ready_high}),
    .started (history_started),
    .counts  (counts),
    .weights (weights),
    .res     (pick)
  );

  // Window length, clamped to 1..WINDOW_MAX
  assign weight_sum = SW'(weights[0]) + SW'(weights[1]) + SW'(weights[2]);

  always_comb begin
    if (weight_sum == '0) begin
      window_len = SW'(1);
    end else if (weight_sum > SW'(WINDOW_MAX)) begin
      window_len = SW'(WINDOW_MAX);
    end else begin
      window_len = weight_sum;
    end
  end

  assign occ = SW'(counts[0]) + SW'(counts[1]) + SW'(counts[2]);

  // Append on every started request and on the first request with a ready level;
  // drop the oldest pick when the window is full, or while trimming an overfull one
  assign append = in_acc && (history_started || !pick.none);
  assign evict  = (in_acc && history_started && (occ >= window_len)) ||
                  (trim && (occ > window_len));

  // New pick lands right after the current entries
  assign wr_sum  = (SW + 1)'(window_start) + (SW + 1)'(occ);
  assign wr_addr = (wr_sum >= (SW + 1)'(WINDOW_MAX)) ?
                   AW'(wr_sum - (SW + 1)'(WINDOW_MAX)) : AW'(wr_sum);

  always_comb begin
    if (!evict) begin
      window_start_next = window_start;
    end else if (window_start == AW'(WINDOW_MAX - 1)) begin
      window_start_next = '0;
    end else begin
      window_start_next = window_start + AW'(1);
    end
  end

  // Ring of past picks; read data tracks the entry at window_start
  wwls_ring #(
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (append),
    .wr_addr (wr_addr),
    .wr_data (pick.level),
    .rd_addr (window_start_next),
    .rd_data (oldest)
  );

  // Per-level counts: drop the evicted pick, add the new one
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      counts_next[i] = counts[i]
                     - CW'(evict && (oldest == LEVEL_W'(i)))
                     + CW'(append && (pick.level == LEVEL_W'(i)));
    end
  end

  assign occ_next  = SW'(counts_next[0]) + SW'(counts_next[1]) + SW'(counts_next[2]);
  assign trim_next = (in_acc || trim) && history_started && (occ_next > window_len);

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start    <= '0;
      history_started <= 1'b0;
      trim            <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      window_start <= window_start_next;
      trim         <= trim_next;
      counts       <= counts_next;
      if (append) begin
        history_started <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      selected_level <= pick.level;
      none_ready     <= pick.none;
    end
  end

endmodule

[rtl/core/wwls_ring.sv]
// Pick history ring: one write port, one registered read port with write bypass.
module wwls_ring
  import wwls_pkg::*;
#(
  parameter int DEPTH = WINDOW_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  level_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output level_t                   rd_data
);

  level_t mem [DEPTH];

  // Write the new pick
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the oldest entry for next cycle, taking a same-cycle write into account
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/wwls_pick.sv]
// Level selection from ready flags, window counts and weights.
module wwls_pick
  import wwls_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic [NUM_LEVELS-1:0]              rdy,
  input  logic                               started,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]    counts  [NUM_LEVELS],
  input  weight_t                            weights [NUM_LEVELS],
  output pick_t                              res
);

  localparam int CW = $clog2(WINDOW_MAX+1);
  localparam int PW = CW + WEIGHT_W;
  localparam int GW = ((CW > WEIGHT_W) ? CW : WEIGHT_W) + 1;

  level_t              a;
  level_t              b;
  logic [PW-1:0]       lhs;
  logic [PW-1:0]       rhs;
  logic signed [GW-1:0] gap0;
  logic signed [GW-1:0] gap1;
  logic signed [GW-1:0] gap2;
  level_t              two_pick;
  level_t              three_pick;

  // Pair of ready levels for the two-ready case
  always_comb begin
    a = LEVEL_HIGH;
    b = LEVEL_MED;
    case (rdy)
      3'b101: begin
        a = LEVEL_HIGH;
        b = LEVEL_LOW;
      end
      3'b110: begin
        a = LEVEL_MED;
        b = LEVEL_LOW;
      end
      default: begin
        a = LEVEL_HIGH;
        b = LEVEL_MED;
      end
    endcase
  end

  // Compare count ratio with weight ratio by cross products
  assign lhs = PW'(counts[a]) * PW'(weights[b]);
  assign rhs = PW'(weights[a]) * PW'(counts[b]);

  always_comb begin
    if (counts[b] == '0) begin
      two_pick = b;
    end else if (lhs > rhs) begin
      two_pick = b;
    end else begin
      two_pick = a;
    end
  end

  // Largest weight-minus-count gap, lowest level wins ties
  assign gap0 = signed'(GW'(weights[0])) - signed'(GW'(counts[0]));
  assign gap1 = signed'(GW'(weights[1])) - signed'(GW'(counts[1]));
  assign gap2 = signed'(GW'(weights[2])) - signed'(GW'(counts[2]));

  always_comb begin
    logic signed [GW-1:0] best;
    best       = gap0;
    three_pick = LEVEL_HIGH;
    if (gap1 > best) begin
      best       = gap1;
      three_pick = LEVEL_MED;
    end
    if (gap2 > best) begin
      three_pick = LEVEL_LOW;
    end
  end

  // Final choice
  always_comb begin
    res.none  = (rdy == '0);
    res.level = LEVEL_HIGH;
    if (!started) begin
      if (rdy[0]) begin
        res.level = LEVEL_HIGH;
      end else if (rdy[1]) begin
        res.level = LEVEL_MED;
      end else if (rdy[2]) begin
        res.level = LEVEL_LOW;
      end else begin
        res.level = LEVEL_HIGH;
      end
    end else begin
      case (rdy) inside
        3'b001:                 res.level = LEVEL_HIGH;
        3'b010:                 res.level = LEVEL_MED;
        3'b100:                 res.level = LEVEL_LOW;
        3'b011, 3'b101, 3'b110: res.level = two_pick;
        3'b111:                 res.level = three_pick;
        default:                res.level = LEVEL_HIGH;
      endcase
    end
  end

endmodule

[test/tb.sv]
// Self-checking testbench for the windowed weighted level scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wwls_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int NUM_PHASES = 12;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int OPENING_RANDOM = 60;
  localparam int TAIL_CYCLES = 4;
  localparam cfg_index_t REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic ready_high;
  logic ready_med;
  logic ready_low;
  logic out_valid;
  logic out_ready;
  level_t selected_level;
  logic none_ready;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  weight_t cfg_data;

  windowed_weighted_level_scheduler_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ready_high(ready_high),
    .ready_med(ready_med),
    .ready_low(ready_low),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .selected_level(selected_level),
    .none_ready(none_ready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Requests are {ready_low, ready_med, ready_high}: bit i flags level i
  logic [2:0] pending_requests [$];
  logic [2:0] opening_requests [$] = '{
    3'b000, 3'b000, 3'b100, 3'b111, 3'b011, 3'b101, 3'b110, 3'b001, 3'b010,
    3'b100, 3'b000, 3'b111, 3'b111, 3'b111, 3'b011, 3'b011, 3'b110, 3'b110,
    3'b101, 3'b101, 3'b111, 3'b111, 3'b111, 3'b000, 3'b111
  };
  pick_t expected_picks [$];

  // Scheduler state mirrored from the handshakes
  weight_t weights [NUM_LEVELS];
  int level_count [NUM_LEVELS];
  level_t pick_log [$];
  bit history_on;

  bit in_taken;
  bit out_taken;
  bit cfg_taken;
  int send_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;
  int mismatches;
  int requests_seen;
  int picks_checked;
  int idle_requests;
  int settings_used;

  // Window length: sum of the weights, clamped to the ring size
  function automatic int window_length();
    int total;
    total = int'(weights[0]) + int'(weights[1]) + int'(weights[2]);
    if (total < 1) total = 1;
    if (total > WINDOW_MAX_DEF) total = WINDOW_MAX_DEF;
    return total;
  endfunction

  // Work out the pick for one accepted request and advance the window
  task automatic predict_pick(input logic [2:0] flags);
    level_t ready_lv [NUM_LEVELS];
    level_t lv;
    level_t a;
    level_t b;
    level_t old;
    int n;
    int best;
    int gap;
    int len;
    pick_t p;
    n = 0;
    lv = LEVEL_HIGH;
    for (int i = 0; i < NUM_LEVELS; i++)
      if (flags[i]) begin
        ready_lv[n] = level_t'(i);
        n++;
      end
    if (!history_on) begin
      // first request: lowest ready level starts the history
      if (n > 0) begin
        lv = ready_lv[0];
        pick_log = {};
        for (int i = 0; i < NUM_LEVELS; i++) level_count[i] = 0;
        pick_log.push_back(lv);
        level_count[lv] = 1;
        history_on = 1'b1;
      end
    end else begin
      if (n == 1) begin
        lv = ready_lv[0];
      end else if (n == 2) begin
        a = ready_lv[0];
        b = ready_lv[1];
        if (level_count[b] == 0) lv = b;
        else if (level_count[a] * int'(weights[b]) > int'(weights[a]) * level_count[b]) lv = b;
        else lv = a;
      end else if (n == 3) begin
        best = int'(weights[0]) - level_count[0];
        lv = LEVEL_HIGH;
        for (int i = 1; i < NUM_LEVELS; i++) begin
          gap = int'(weights[i]) - level_count[i];
          if (gap > best) begin
            best = gap;
            lv = level_t'(i);
          end
        end
      end
      // drop the oldest picks until there is room, then append
      len = window_length();
      while (pick_log.size() >= len && pick_log.size() > 0) begin
        old = pick_log.pop_front();
        level_count[old]--;
      end
      pick_log.push_back(lv);
      level_count[lv]++;
    end
    p.level = lv;
    p.none = (n == 0);
    expected_picks.push_back(p);
  endtask

  function automatic logic [2:0] random_request(input int bias);
    logic [2:0] r;
    for (int i = 0; i < 3; i++) r[i] = ($urandom_range(99) < bias);
    return r;
  endfunction

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Request driver: launch from the pending queue, hold until taken
  always @(negedge clk) begin : driver
    logic [2:0] req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        in_valid <= 1'b1;
        ready_high <= req[0];
        ready_med <= req[1];
        ready_low <= req[2];
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: track handshakes, predict, check results, watch for a hang
  always @(posedge clk) begin : monitor
    pick_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst) begin
      in_taken = (in_valid && in_ready) === 1'b1;
      out_taken = (out_valid && out_ready) === 1'b1;
      cfg_taken = (cfg_valid && cfg_ready) === 1'b1;
      // a request taken at this edge still sees the old weights
      if (in_taken) begin
        requests_seen++;
        if (!(ready_high || ready_med || ready_low)) idle_requests++;
        predict_pick({ready_low, ready_med, ready_high});
      end
      if (cfg_taken) begin
        case (cfg_index)
          REG_WEIGHT_HIGH: weights[0] = cfg_data;
          REG_WEIGHT_MED: weights[1] = cfg_data;
          REG_WEIGHT_LOW: weights[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_taken) begin
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: level %0d none_ready %0b", selected_level, none_ready);
        end else begin
          want = expected_picks.pop_front();
          picks_checked++;
          if (want.level !== selected_level || want.none !== none_ready) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected level %0d none_ready %0b, ",
                        "got level %0d none_ready %0b"},
                       picks_checked, want.level, want.none, selected_level, none_ready);
          end
        end
      end
      if (in_taken || out_taken || cfg_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_picks.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_index_t idx, input weight_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_weights(input weight_t wh, input weight_t wm, input weight_t wl);
    write_reg(REG_WEIGHT_HIGH, wh);
    write_reg(REG_WEIGHT_MED, wm);
    write_reg(REG_WEIGHT_LOW, wl);
    settings_used++;
  endtask

  // Wait until every request is taken and every result has come back;
  // sample at the rising edge so the driver cannot launch a request meanwhile
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_picks.size() != 0);
  endtask

  // Stimulus: phases of weight settings and idling, directed opening first
  initial begin
    in_valid = 1'b0;
    ready_high = 1'b0;
    ready_med = 1'b0;
    ready_low = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WEIGHT_HIGH;
    cfg_data = '0;
    weights[0] = WEIGHT_HIGH_RST;
    weights[1] = WEIGHT_MED_RST;
    weights[2] = WEIGHT_LOW_RST;
    for (int i = 0; i < NUM_LEVELS; i++) level_count[i] = 0;
    history_on = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    quiet_cycles = 0;
    mismatches = 0;
    requests_seen = 0;
    picks_checked = 0;
    idle_requests = 0;
    settings_used = 1;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0; sink_stall_pct = 0; end
        1: begin send_idle_pct = 55; sink_stall_pct = 0; end
        2: begin send_idle_pct = 0; sink_stall_pct = 55; end
        default: begin send_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      case (phase)
        0: ;
        1: program_weights(5'd1, 5'd1, 5'd1);
        2: program_weights(5'd21, 5'd21, 5'd21);
        3: program_weights(5'd31, 5'd31, 5'd31);
        4: begin
          // all-zero weights shrink the window to one pick
          program_weights(5'd0, 5'd0, 5'd0);
          write_reg(REG_UNUSED, 5'd31);
        end
        5: program_weights(5'd21, 5'd1, 5'd1);
        6: program_weights(5'd1, 5'd1, 5'd21);
        7: program_weights(5'd1, 5'd21, 5'd1);
        10: program_weights(weight_t'($urandom_range(31)), weight_t'($urandom_range(31)),
                            weight_t'($urandom_range(31)));
        default: program_weights(weight_t'($urandom_range(21, 1)),
                                 weight_t'($urandom_range(21, 1)),
                                 weight_t'($urandom_range(21, 1)));
      endcase
      if (phase == 0) begin
        foreach (opening_requests[i]) pending_requests.push_back(opening_requests[i]);
        for (int i = 0; i < OPENING_RANDOM; i++)
          pending_requests.push_back(random_request(75));
      end else begin
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
          pending_requests.push_back(random_request(phase % 3 == 0 ? 50 :
                                                    phase % 3 == 1 ? 75 : 90));
      end
    end

    // Drain and let the pipeline settle
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d requests (%0d with no level ready) across %0d weight settings",
             requests_seen, idle_requests, settings_used);
    $display("Checked %0d picks under four idle and stall patterns, %0d mismatches",
             picks_checked, mismatches);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
